### design/bic_pkg.sv
// Shared types, constants and helper functions of the banked interrupt controller.
package bic_pkg;

   localparam int BANK_COUNT     = 4;
   localparam int LINES_PER_BANK = 32;
   localparam int BANK_W         = $clog2(BANK_COUNT);
   localparam int BIT_W          = $clog2(LINES_PER_BANK);
   localparam int LINE_W         = BANK_W + BIT_W;
   localparam int BANK_CNT_W     = $clog2(BANK_COUNT + 1);
   localparam int CFG_W          = 3;
   localparam int CSR_IDX_W      = 1;

   typedef logic [LINES_PER_BANK-1:0] bank_word_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_FLAG   = 2'd0,
      REG_ENABLE = 2'd1,
      REG_ACK    = 2'd2,
      REG_LEVEL  = 2'd3
   } reg_sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BANKS_IN_USE = 1'd0,
      CSR_MAIN_BANKS   = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture request beat
      logic exec;   // apply request to bank state
      logic find;   // priority-encode pending lines
   } dp_cmd_type;

   // Banks present, held to 1..BANK_COUNT
   function automatic logic [BANK_CNT_W-1:0] eff_banks(input logic [CFG_W-1:0] v);
      logic [BANK_CNT_W-1:0] n;
      if (v == '0) begin
         n = BANK_CNT_W'(1);
      end else if (int'(v) > BANK_COUNT) begin
         n = BANK_CNT_W'(BANK_COUNT);
      end else begin
         n = BANK_CNT_W'(v);
      end
      return n;
   endfunction

   // Main banks, held to 1..n
   function automatic logic [BANK_CNT_W-1:0] eff_main(input logic [CFG_W-1:0] v,
                                                     input logic [BANK_CNT_W-1:0] n);
      logic [BANK_CNT_W-1:0] m;
      if (v == '0) begin
         m = BANK_CNT_W'(1);
      end else if (int'(v) > int'(n)) begin
         m = n;
      end else begin
         m = BANK_CNT_W'(v);
      end
      return m;
   endfunction

   // Index of highest set bit, 0 when none
   function automatic logic [BIT_W-1:0] hi_bit(input bank_word_type bits);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int k = 0; k < LINES_PER_BANK; k++) begin
         if (bits[k]) begin
            idx = BIT_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

### design/bic_ctrl.sv
// Sequencer of the banked interrupt controller: accept, execute, encode, report.
module bic_ctrl import bic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output dp_cmd_type cmd,
   output logic       rsp_valid
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FIND;
         end
         ST_FIND: begin
            cmd.find     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/bic_dp.sv
// Datapath of the banked interrupt controller: bank registers, config and line encoders.
module bic_dp import bic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [1:0]            req_op,
   input  logic [BANK_W-1:0]     req_bank,
   input  logic [1:0]            req_reg_sel,
   input  bank_word_type         req_write_data,
   input  bank_word_type         req_line_levels,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_write_data,
   output bank_word_type         rsp_read_data,
   output logic                  rsp_main_pending,
   output logic [LINE_W-1:0]     rsp_main_line,
   output logic                  rsp_cascade_pending,
   output logic [LINE_W-1:0]     rsp_cascade_line
);

   // request beat
   op_type            op_ff;
   logic [BANK_W-1:0] bank_ff;
   reg_sel_type       sel_ff;
   bank_word_type     wdata_ff;
   bank_word_type     levels_ff;

   bank_word_type flag_ff   [BANK_COUNT];
   bank_word_type enable_ff [BANK_COUNT];
   bank_word_type level_ff  [BANK_COUNT];
   bank_word_type lost_ff   [BANK_COUNT];

   logic [CFG_W-1:0] banks_in_use_ff;
   logic [CFG_W-1:0] main_banks_ff;

   bank_word_type     rd_ff, rd_in;
   logic              main_pending_ff, main_pending_in;
   logic [LINE_W-1:0] main_line_ff, main_line_in;
   logic              casc_pending_ff, casc_pending_in;
   logic [LINE_W-1:0] casc_line_ff, casc_line_in;

   logic [BANK_CNT_W-1:0] n_banks;
   logic [BANK_CNT_W-1:0] m_banks;
   logic                  in_range;
   bank_word_type         cur_flag, cur_enable, cur_level, cur_lost;
   bank_word_type         flag_in, enable_in, level_in, lost_in;

   function automatic bank_word_type req_rise(input bank_word_type now,
                                              input bank_word_type was);
      return now & ~was;
   endfunction

   assign n_banks  = eff_banks(banks_in_use_ff);
   assign m_banks  = eff_main(main_banks_ff, n_banks);
   assign in_range = (BANK_CNT_W'(bank_ff) < n_banks);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_op);
         bank_ff   <= req_bank;
         sel_ff    <= reg_sel_type'(req_reg_sel);
         wdata_ff  <= req_write_data;
         levels_ff <= req_line_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_in_use_ff <= CFG_W'(1);
         main_banks_ff   <= CFG_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BANKS_IN_USE: banks_in_use_ff <= csr_write_data;
            CSR_MAIN_BANKS:   main_banks_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cur_flag   = flag_ff[bank_ff];
   assign cur_enable = enable_ff[bank_ff];
   assign cur_level  = level_ff[bank_ff];
   assign cur_lost   = lost_ff[bank_ff];

   always_comb begin
      flag_in   = cur_flag;
      enable_in = cur_enable;
      level_in  = cur_level;
      lost_in   = cur_lost;
      rd_in     = '0;
      if (in_range) begin
         unique case (op_ff)
            OP_TICK: begin
               flag_in  = cur_flag | (req_rise(levels_ff, cur_level) & cur_enable);
               level_in = levels_ff;
            end
            OP_WRITE: begin
               case (sel_ff)
                  REG_ENABLE: begin
                     // line switched on while already high and unflagged: edge missed
                     lost_in   = cur_lost | (wdata_ff & ~cur_enable & cur_level & ~cur_flag);
                     enable_in = wdata_ff;
                  end
                  REG_ACK: begin
                     flag_in = cur_flag & ~wdata_ff;
                     lost_in = cur_lost & ~wdata_ff;
                  end
                  default: ;
               endcase
            end
            OP_READ: begin
               case (sel_ff)
                  REG_FLAG:   rd_in = cur_flag;
                  REG_ENABLE: rd_in = cur_enable;
                  REG_LEVEL:  rd_in = cur_level;
                  default:    rd_in = '0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANK_COUNT; b++) begin
            flag_ff[b]   <= '0;
            enable_ff[b] <= '0;
            level_ff[b]  <= '0;
            lost_ff[b]   <= '0;
         end
      end else if (cmd.exec && in_range) begin
         flag_ff[bank_ff]   <= flag_in;
         enable_ff[bank_ff] <= enable_in;
         level_ff[bank_ff]  <= level_in;
         lost_ff[bank_ff]   <= lost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_ff <= rd_in;
      end
   end

   // highest bank wins, later iterations override
   always_comb begin
      bank_word_type pend;
      main_pending_in = 1'b0;
      main_line_in    = '0;
      casc_pending_in = 1'b0;
      casc_line_in    = '0;
      for (int b = 0; b < BANK_COUNT; b++) begin
         pend = flag_ff[b] | lost_ff[b];
         if (pend != '0) begin
            if (BANK_CNT_W'(b) < m_banks) begin
               main_pending_in = 1'b1;
               main_line_in    = {BANK_W'(b), hi_bit(pend)};
            end else if (BANK_CNT_W'(b) < n_banks) begin
               casc_pending_in = 1'b1;
               casc_line_in    = {BANK_W'(b), hi_bit(pend)};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find) begin
         main_pending_ff <= main_pending_in;
         main_line_ff    <= main_line_in;
         casc_pending_ff <= casc_pending_in;
         casc_line_ff    <= casc_line_in;
      end
   end

   assign rsp_read_data       = rd_ff;
   assign rsp_main_pending    = main_pending_ff;
   assign rsp_main_line       = main_line_ff;
   assign rsp_cascade_pending = casc_pending_ff;
   assign rsp_cascade_line    = casc_line_ff;

endmodule

### design/banked_interrupt_controller.sv
// An accepted beat is applied to its bank in the execute state, then encoded in the find
// state, which registers the results and the result strobe. A new beat is accepted only
// from idle; busy is high in execute and find. The response strobe cannot be stalled.
// Synchronous reset clears all bank registers and sets both config registers to 1.
// Config writes are taken on any cycle with csr_write_enable high.
module banked_interrupt_controller import bic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [BANK_W-1:0]     req_bank,
   input  logic [1:0]            req_reg_sel,
   input  logic [31:0]           req_write_data,
   input  logic [31:0]           req_line_levels,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_write_data,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_main_pending,
   output logic [LINE_W-1:0]     rsp_main_line,
   output logic                  rsp_cascade_pending,
   output logic [LINE_W-1:0]     rsp_cascade_line
);

   dp_cmd_type cmd;

   bic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   bic_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_op              (req_op),
      .req_bank            (req_bank),
      .req_reg_sel         (req_reg_sel),
      .req_write_data      (req_write_data),
      .req_line_levels     (req_line_levels),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_read_data       (rsp_read_data),
      .rsp_main_pending    (rsp_main_pending),
      .rsp_main_line       (rsp_main_line),
      .rsp_cascade_pending (rsp_cascade_pending),
      .rsp_cascade_line    (rsp_cascade_line)
   );

endmodule
